// ----- sv/accf_pkg.sv -----
// Shared types, constants and the base classifier for the column conservation filter.
// No dependencies; every other file apart from accf_ram refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package accf_pkg;

    localparam int NUM_TREE = 8;
    localparam int SLOT_W   = (NUM_TREE > 1) ? $clog2(NUM_TREE) : 1;

    localparam int CNT_W    = 7;
    localparam int NUM_CLS  = 5;                // A, G, C, T, gap
    localparam int NUM_FLD  = NUM_CLS + 1;      // plus group total
    localparam int TOT_IDX  = NUM_CLS;
    localparam int WORD_W   = CNT_W * NUM_FLD;

    localparam int THR_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = THR_W + CNT_W;
    localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0]       CHAR_N  = 8'h4E;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_THR = 1'b1;

    typedef enum logic [2:0] {
        CLS_A,
        CLS_G,
        CLS_C,
        CLS_T,
        CLS_GAP,
        CLS_N,
        CLS_OTHER
    } t_cls;

    // majority code when no class was counted
    localparam logic [2:0] MAJ_NONE = 3'd5;

    typedef logic [NUM_FLD-1:0][CNT_W-1:0] t_cnt_word;

    typedef struct packed {
        logic [7:0] base_char;
        logic       is_out_group;
        logic [3:0] tree_slot;
        logic       column_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic [2:0] slot_index;
        logic       last_of_column;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] maj;
        logic       nonzero;
        logic       meets;
    } t_grp_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_RD_IN,
        ST_LD_IN,
        ST_LD_OUT,
        ST_EVAL,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    function automatic t_cls classify(input logic [7:0] ch);
        logic [7:0] u;
        t_cls       c;
        begin
            u = ch;
            if (ch >= 8'h61 && ch <= 8'h7A) begin
                u = ch - 8'd32;
            end
            case (u)
                8'h41:   c = CLS_A;     // 'A'
                8'h47:   c = CLS_G;     // 'G'
                8'h43:   c = CLS_C;     // 'C'
                8'h54:   c = CLS_T;     // 'T'
                8'h2D:   c = CLS_GAP;   // '-'
                8'h4E:   c = CLS_N;     // 'N'
                default: c = CLS_OTHER;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/alignment_column_conservation_filter_unit.sv -----
// Top level of the column conservation filter: sequencer, count and character RAMs.
// Depends on accf_pkg, accf_ram and accf_judge.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_in_data  (t_in_beat)
//  out       output     o_out_valid / i_out_ready   o_out_data (t_out_beat)
//  cfg       input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// A base is accepted with the count RAM read, then modified and written back.
// A column-end base then passes through two reads of the count RAM, evaluation and decision.
// A kept column then emits one beat per tree slot, each read through the char RAM
// port and then loaded into the output register, held while the output is stalled.
// Synchronous reset; counts and slot chars are qualified by valid bits, no clearing pass.
// Input is accepted while the last emitted beat still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module alignment_column_conservation_filter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire accf_pkg::t_in_beat              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output accf_pkg::t_out_beat                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [accf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [accf_pkg::THR_W-1:0]      i_cfg_data
);

    accf_pkg::t_state                  r_state, n_state;
    logic [1:0]                        r_grp_vld, n_grp_vld;
    logic [accf_pkg::NUM_TREE-1:0]     r_chr_vld, n_chr_vld;
    logic [accf_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic                              r_o_valid, n_o_valid;
    logic [accf_pkg::THR_W-1:0]        r_thr_in, r_thr_out;

    accf_pkg::t_in_beat                r_item;
    accf_pkg::t_cnt_word               r_in_word, r_out_word;
    accf_pkg::t_out_beat               r_o_data, n_o_data;

    logic                              in_acc;
    logic                              slot_ok;
    logic                              ld_in, ld_out, judge_en, o_load;
    logic                              slot_last;
    logic                              cnt_re, cnt_we, cnt_raddr;
    logic [accf_pkg::WORD_W-1:0]       cnt_rdata;
    accf_pkg::t_cnt_word               cnt_word, cnt_upd;
    accf_pkg::t_cls                    cls;
    logic                              chr_re;
    logic [7:0]                        chr_rdata;
    accf_pkg::t_grp_res                in_res, out_res;
    logic                              keep;

    assign o_in_ready  = (r_state == accf_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_ok     = (32'(i_in_data.tree_slot) < accf_pkg::NUM_TREE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign slot_last   = (r_slot == accf_pkg::SLOT_W'(accf_pkg::NUM_TREE - 1));

    // one word per group: five class counts and the total, saturating
    accf_ram #(
        .WIDTH(accf_pkg::WORD_W),
        .DEPTH(2)
    ) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(r_item.is_out_group),
        .i_wdata(cnt_upd),
        .i_re   (cnt_re),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rdata)
    );

    accf_ram #(
        .WIDTH(8),
        .DEPTH(accf_pkg::NUM_TREE)
    ) u_chr_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && slot_ok),
        .i_waddr(i_in_data.tree_slot[accf_pkg::SLOT_W-1:0]),
        .i_wdata(i_in_data.base_char),
        .i_re   (chr_re),
        .i_raddr(r_slot),
        .o_rdata(chr_rdata)
    );

    accf_judge u_judge_in (
        .i_clk (i_clk),
        .i_en  (judge_en),
        .i_word(r_in_word),
        .i_thr (r_thr_in),
        .o_res (in_res)
    );

    accf_judge u_judge_out (
        .i_clk (i_clk),
        .i_en  (judge_en),
        .i_word(r_out_word),
        .i_thr (r_thr_out),
        .o_res (out_res)
    );

    // read-modify-write of the group word; an entry never written this column reads zero
    always_comb begin
        cls      = accf_pkg::classify(r_item.base_char);
        cnt_word = r_grp_vld[r_item.is_out_group] ? accf_pkg::t_cnt_word'(cnt_rdata) : '0;
        cnt_upd  = cnt_word;
        if (cls != accf_pkg::CLS_N) begin
            if (cls != accf_pkg::CLS_OTHER && cnt_word[cls] != accf_pkg::CNT_MAX) begin
                cnt_upd[cls] = cnt_word[cls] + 1'b1;
            end
            if (cnt_word[accf_pkg::TOT_IDX] != accf_pkg::CNT_MAX) begin
                cnt_upd[accf_pkg::TOT_IDX] = cnt_word[accf_pkg::TOT_IDX] + 1'b1;
            end
        end
    end

    assign keep = in_res.nonzero && (in_res.maj != accf_pkg::MAJ_NONE) && in_res.meets &&
                  (!out_res.nonzero || (out_res.maj != in_res.maj) || !out_res.meets);

    always_comb begin
        n_state   = r_state;
        n_grp_vld = r_grp_vld;
        n_chr_vld = r_chr_vld;
        n_slot    = r_slot;
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_raddr = 1'b0;
        chr_re    = 1'b0;
        ld_in     = 1'b0;
        ld_out    = 1'b0;
        judge_en  = 1'b0;
        o_load    = 1'b0;
        n_o_data  = r_o_data;

        case (r_state)
            accf_pkg::ST_IDLE: begin
                if (in_acc) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = i_in_data.is_out_group;
                    if (slot_ok) begin
                        n_chr_vld[i_in_data.tree_slot[accf_pkg::SLOT_W-1:0]] = 1'b1;
                    end
                    n_state = accf_pkg::ST_UPD;
                end
            end
            accf_pkg::ST_UPD: begin
                cnt_we = 1'b1;
                n_grp_vld[r_item.is_out_group] = 1'b1;
                n_state = r_item.column_end ? accf_pkg::ST_RD_IN : accf_pkg::ST_IDLE;
            end
            accf_pkg::ST_RD_IN: begin
                cnt_re    = 1'b1;
                cnt_raddr = 1'b0;
                n_state   = accf_pkg::ST_LD_IN;
            end
            accf_pkg::ST_LD_IN: begin
                ld_in     = 1'b1;
                cnt_re    = 1'b1;
                cnt_raddr = 1'b1;
                n_state   = accf_pkg::ST_LD_OUT;
            end
            accf_pkg::ST_LD_OUT: begin
                ld_out  = 1'b1;
                n_state = accf_pkg::ST_EVAL;
            end
            accf_pkg::ST_EVAL: begin
                judge_en = 1'b1;
                n_state  = accf_pkg::ST_DECIDE;
            end
            accf_pkg::ST_DECIDE: begin
                n_grp_vld = '0;
                n_slot    = '0;
                if (keep) begin
                    n_state = accf_pkg::ST_EMIT_RD;
                end else begin
                    n_chr_vld = '0;
                    n_state   = accf_pkg::ST_IDLE;
                end
            end
            accf_pkg::ST_EMIT_RD: begin
                chr_re  = 1'b1;
                n_state = accf_pkg::ST_EMIT_LD;
            end
            accf_pkg::ST_EMIT_LD: begin
                // hold the read data until the output register frees up
                if (!r_o_valid || i_out_ready) begin
                    o_load                  = 1'b1;
                    n_o_data.out_char       = r_chr_vld[r_slot] ? chr_rdata : accf_pkg::CHAR_N;
                    n_o_data.slot_index     = 3'(r_slot);
                    n_o_data.last_of_column = slot_last;
                    if (slot_last) begin
                        n_chr_vld = '0;
                        n_state   = accf_pkg::ST_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = accf_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = accf_pkg::ST_IDLE;
            end
        endcase

        if (o_load) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= accf_pkg::ST_IDLE;
            r_grp_vld <= '0;
            r_chr_vld <= '0;
            r_slot    <= '0;
            r_o_valid <= 1'b0;
            r_thr_in  <= accf_pkg::THR_RESET;
            r_thr_out <= accf_pkg::THR_RESET;
        end else begin
            r_state   <= n_state;
            r_grp_vld <= n_grp_vld;
            r_chr_vld <= n_chr_vld;
            r_slot    <= n_slot;
            r_o_valid <= n_o_valid;
            if (i_cfg_we && i_cfg_idx == accf_pkg::CFG_IN_THR) begin
                r_thr_in <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == accf_pkg::CFG_OUT_THR) begin
                r_thr_out <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (ld_in) begin
            r_in_word <= r_grp_vld[0] ? accf_pkg::t_cnt_word'(cnt_rdata) : '0;
        end
        if (ld_out) begin
            r_out_word <= r_grp_vld[1] ? accf_pkg::t_cnt_word'(cnt_rdata) : '0;
        end
        r_o_data <= n_o_data;
    end

endmodule

`default_nettype wire

// ----- sv/accf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; read data holds while the read enable is low.
`timescale 1ns / 1ps
`default_nettype none

module accf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/accf_judge.sv -----
// Per-group evaluation: majority class, threshold product, then the Q1.16 compare.
// Depends on accf_pkg. o_res is registered and stable from the cycle after i_en.
`timescale 1ns / 1ps
`default_nettype none

module accf_judge (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire accf_pkg::t_cnt_word         i_word,
    input  wire logic [accf_pkg::THR_W-1:0]  i_thr,
    output accf_pkg::t_grp_res               o_res
);

    logic [2:0]                    maj;
    logic [accf_pkg::CNT_W-1:0]    best;
    logic [accf_pkg::CNT_W-1:0]    maj_cnt;
    logic [accf_pkg::PROD_W-1:0]   prod;

    logic [2:0]                    r_maj;
    logic [accf_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_nonzero;
    logic [accf_pkg::PROD_W-1:0]   r_prod;

    // first strict maximum in A, G, C, T, gap order
    always_comb begin
        best = '0;
        maj  = accf_pkg::MAJ_NONE;
        for (int i = 0; i < accf_pkg::NUM_CLS; i++) begin
            if (i_word[i] > best) begin
                best = i_word[i];
                maj  = 3'(i);
            end
        end
        maj_cnt = best;
        prod    = accf_pkg::PROD_W'(i_thr) * accf_pkg::PROD_W'(i_word[accf_pkg::TOT_IDX]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_maj     <= maj;
            r_cnt     <= maj_cnt;
            r_nonzero <= (i_word[accf_pkg::TOT_IDX] != '0);
            r_prod    <= prod;
        end
    end

    // count * 2^16 >= thr * total
    always_comb begin
        o_res.maj     = r_maj;
        o_res.nonzero = r_nonzero;
        o_res.meets   = (accf_pkg::PROD_W'({r_cnt, {accf_pkg::FRAC_W{1'b0}}}) >= r_prod);
    end

endmodule

`default_nettype wire
